// File: hdl/voxel_subvolume_address_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Voxel sub-volume address generator: assertion macros
// Concurrent assertion shorthands used by the top level. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SUBVOLUME_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define VOXEL_SUBVOLUME_ADDRESS_GENERATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define VSAG_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("vsag: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define VSAG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsag: implication violated");

// The consequent holds in the cycle after the antecedent.
`define VSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsag: next-cycle check violated");

`else

`define VSAG_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define VSAG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define VSAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/vsag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel sub-volume address generator package
// Widths, register indexes, cut modes, reset values and the structures that
// pass between the plan stage, the walk engine and the top level.
// ----------------------------------------------------------------------------
package vsag_pkg;

    localparam int DIM_W   = 11;
    localparam int PAGE_W  = 10;
    localparam int OFS_W   = 31;
    localparam int CFG_W   = 33;
    localparam int IDX_W   = 3;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int LO_W    = AREA_W + 1;
    localparam int STEP_W  = AREA_W + 1;

    typedef logic [IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_VOLUME_DIMS = 3'd0;
    localparam t_cfg_index REG_UNIT_SIZE   = 3'd1;
    localparam t_cfg_index REG_CUT_MODE    = 3'd2;
    localparam t_cfg_index REG_PAGE_INDEX  = 3'd3;
    localparam t_cfg_index REG_BOX_MIN     = 3'd4;
    localparam t_cfg_index REG_BOX_MAX     = 3'd5;

    typedef enum logic [1:0] {
        CUT_X    = 2'd0,
        CUT_Y    = 2'd1,
        CUT_Z    = 2'd2,
        CUT_CUBE = 2'd3
    } t_cut_mode;

    localparam logic [1:0] UNIT_ONE = 2'd1;
    localparam logic [1:0] UNIT_TWO = 2'd2;

    localparam logic [CFG_W-1:0]  RST_VOLUME_DIMS = 33'd4198401;
    localparam logic [1:0]        RST_UNIT_SIZE   = UNIT_ONE;
    localparam t_cut_mode         RST_CUT_MODE    = CUT_Z;
    localparam logic [PAGE_W-1:0] RST_PAGE_INDEX  = '0;
    localparam logic [CFG_W-1:0]  RST_BOX_MIN     = '0;
    localparam logic [CFG_W-1:0]  RST_BOX_MAX     = 33'd4198401;

    // Everything the walk needs, derived from the configuration registers.
    typedef struct packed {
        logic              bad;
        logic              unit2;
        logic [DIM_W-1:0]  ext_h;
        logic [DIM_W-1:0]  ext_v;
        logic [DIM_W-1:0]  ext_d;
        logic [DIM_W-1:0]  ext_v_m1;
        logic [DIM_W-1:0]  hi;
        logic [LO_W-1:0]   lo;
        logic [AREA_W-1:0] dxdy;
        logic [AREA_W-1:0] vs;
        logic [STEP_W-1:0] hs_u;
        logic [STEP_W-1:0] vs_u;
        logic [STEP_W-1:0] ds_u;
    } t_plan;

    typedef struct packed {
        logic [OFS_W-1:0] source_offset;
        logic [OFS_W-1:0] dest_offset;
        logic             last;
        logic             error;
        logic             valid_res;
    } t_result;

endpackage

// File: hdl/voxel_subvolume_address_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel sub-volume address generator
// Walks a slice or sub-cube of a voxel volume and issues one source and
// destination byte offset pair per request.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         i_in_valid / o_in_stall     i_restart
//   result    out        o_out_valid / i_out_stall   offsets, last, error, valid_res
//   config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// One request is taken per cycle while o_in_stall is low; its result passes
// through the input register and then the output register.
// The walk counters and cursors update on each fired request.
// The derived walk plan is registered from the configuration registers.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled result holds its register while one further request waits in
// the input register; o_in_stall rises only when both are occupied.
// ----------------------------------------------------------------------------
`include "voxel_subvolume_address_generator_top_macros.svh"

module voxel_subvolume_address_generator_top
    import vsag_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_restart,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OFS_W-1:0] o_source_offset,
    output logic [OFS_W-1:0] o_dest_offset,
    output logic             o_last,
    output logic             o_error,
    output logic             o_valid_res
);

    t_plan   plan;
    t_result walk_result;
    t_result r_result;

    logic r_in_valid, n_in_valid;
    logic r_in_restart;
    logic r_out_valid, n_out_valid;
    logic in_xfer, out_free, fire;

    vsag_plan #(
        .MAX_DIM (MAX_DIM)
    ) u_plan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plan      (plan)
    );

    vsag_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_restart (r_in_restart),
        .i_plan    (plan),
        .o_result  (walk_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_restart <= i_restart;
        end
        if (fire) begin
            r_result <= walk_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source_offset = r_result.source_offset;
    assign o_dest_offset   = r_result.dest_offset;
    assign o_last          = r_result.last;
    assign o_error         = r_result.error;
    assign o_valid_res     = r_result.valid_res;

    // An error result is a lone, final result with zero offsets.
    `VSAG_ASSERT_IMPLIES(a_error_form, i_clk, i_rst_n, o_out_valid && o_error,
        o_last && o_valid_res && (o_source_offset == '0) && (o_dest_offset == '0))

    // An advance with no walk active carries nothing else.
    `VSAG_ASSERT_IMPLIES(a_idle_form, i_clk, i_rst_n, o_out_valid && !o_valid_res,
        !o_last && !o_error && (o_source_offset == '0) && (o_dest_offset == '0))

    // A restart always yields a valid result at the start of the output chunk.
    `VSAG_ASSERT_NEXT(a_restart_result, i_clk, i_rst_n, fire && r_in_restart,
        o_out_valid && o_valid_res && (o_dest_offset == '0))

    // A waiting request is not dropped while the output is blocked.
    `VSAG_ASSERT_NEXT(a_hold_request, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid)

endmodule

// File: hdl/vsag_plan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel sub-volume address generator: configuration and plan stage
// Holds the configuration registers and registers the walk plan derived
// from them: extents, strides, start terms and the validity check.
// ----------------------------------------------------------------------------
module vsag_plan
    import vsag_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_plan            o_plan
);

    localparam logic [DIM_W:0] DIM_LIMIT = (DIM_W + 1)'(MAX_DIM);

    logic [CFG_W-1:0]  r_volume_dims;
    logic [1:0]        r_unit_size;
    t_cut_mode         r_cut_mode;
    logic [PAGE_W-1:0] r_page_index;
    logic [CFG_W-1:0]  r_box_min;
    logic [CFG_W-1:0]  r_box_max;

    t_plan r_plan;
    t_plan n_plan;

    logic [DIM_W-1:0]  dx, dy, dz, n0, n1, n2, x0, x1, x2, pg;
    logic [DIM_W-1:0]  mul_a, addend, lim0, lim1, limp;
    logic [AREA_W-1:0] dxdy, mul_lo, hs, vs, ds;
    logic              is_cube, u2, dims_bad, unit_bad, page_bad, box_bad, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_dims <= RST_VOLUME_DIMS;
            r_unit_size   <= RST_UNIT_SIZE;
            r_cut_mode    <= RST_CUT_MODE;
            r_page_index  <= RST_PAGE_INDEX;
            r_box_min     <= RST_BOX_MIN;
            r_box_max     <= RST_BOX_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VOLUME_DIMS: r_volume_dims <= i_cfg_data;
                REG_UNIT_SIZE:   r_unit_size   <= i_cfg_data[1:0];
                REG_CUT_MODE:    r_cut_mode    <= t_cut_mode'(i_cfg_data[1:0]);
                REG_PAGE_INDEX:  r_page_index  <= i_cfg_data[PAGE_W-1:0];
                REG_BOX_MIN:     r_box_min     <= i_cfg_data;
                REG_BOX_MAX:     r_box_max     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx = r_volume_dims[DIM_W-1:0];
        dy = r_volume_dims[2*DIM_W-1:DIM_W];
        dz = r_volume_dims[3*DIM_W-1:2*DIM_W];
        n0 = r_box_min[DIM_W-1:0];
        n1 = r_box_min[2*DIM_W-1:DIM_W];
        n2 = r_box_min[3*DIM_W-1:2*DIM_W];
        x0 = r_box_max[DIM_W-1:0];
        x1 = r_box_max[2*DIM_W-1:DIM_W];
        x2 = r_box_max[3*DIM_W-1:2*DIM_W];
        pg = {1'b0, r_page_index};
        u2 = (r_unit_size == UNIT_TWO);

        dxdy = dx * dy;

        // Slice defaults match the z-slice; the other modes override.
        mul_a   = n1;
        addend  = n0;
        n_plan.hi = pg;
        hs      = AREA_W'(1);
        vs      = AREA_W'(dx);
        ds      = '0;
        lim0    = dx;
        lim1    = dy;
        limp    = dz;
        is_cube = 1'b0;
        case (r_cut_mode)
            CUT_X: begin
                addend    = pg;
                n_plan.hi = n0;
                hs        = dxdy;
                lim0      = dz;
                limp      = dx;
            end
            CUT_Y: begin
                mul_a     = pg;
                n_plan.hi = n1;
                vs        = dxdy;
                lim1      = dz;
                limp      = dy;
            end
            CUT_Z: ;
            CUT_CUBE: begin
                n_plan.hi = n2;
                ds        = dxdy;
                is_cube   = 1'b1;
            end
            default: ;
        endcase

        mul_lo = mul_a * dx;

        dims_bad = (dx == '0) || (dy == '0) || (dz == '0)
                || ({1'b0, dx} > DIM_LIMIT) || ({1'b0, dy} > DIM_LIMIT)
                || ({1'b0, dz} > DIM_LIMIT);
        unit_bad = (r_unit_size != UNIT_ONE) && (r_unit_size != UNIT_TWO);
        page_bad = !is_cube && (pg >= limp);
        box_bad  = (x0 > lim0) || (x1 > lim1) || (is_cube && (x2 > dz));
        empty    = (x0 <= n0) || (x1 <= n1) || (is_cube && (x2 <= n2));

        // An empty extent still walks as one voxel when it shows up mid-walk.
        n_plan.ext_h    = (x0 > n0) ? (x0 - n0) : DIM_W'(1);
        n_plan.ext_v    = (x1 > n1) ? (x1 - n1) : DIM_W'(1);
        n_plan.ext_d    = (is_cube && (x2 > n2)) ? (x2 - n2) : DIM_W'(1);
        n_plan.ext_v_m1 = n_plan.ext_v - DIM_W'(1);

        n_plan.bad   = dims_bad || unit_bad || page_bad || box_bad || empty;
        n_plan.unit2 = u2;
        n_plan.lo    = LO_W'(mul_lo) + LO_W'(addend);
        n_plan.dxdy  = dxdy;
        n_plan.vs    = vs;
        n_plan.hs_u  = u2 ? {hs, 1'b0} : {1'b0, hs};
        n_plan.vs_u  = u2 ? {vs, 1'b0} : {1'b0, vs};
        n_plan.ds_u  = u2 ? {ds, 1'b0} : {1'b0, ds};
    end

    // Refreshed every cycle from the configuration registers, one register behind them.
    always_ff @(posedge i_clk) begin
        r_plan <= n_plan;
    end

    assign o_plan = r_plan;

endmodule

// File: hdl/vsag_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel sub-volume address generator: walk engine
// Keeps the voxel counters and the source and destination cursors, and
// forms the result for one restart or advance per transfer.
// ----------------------------------------------------------------------------
module vsag_walk
    import vsag_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic    i_restart,
    input  t_plan   i_plan,
    output t_result o_result
);

    logic [DIM_W-1:0] r_horiz, r_vert, r_depth;
    logic [DIM_W-1:0] n_horiz, n_vert, n_depth;
    logic [OFS_W-1:0] r_row_base, r_src, r_dst;
    logic [OFS_W-1:0] n_row_base, n_src, n_dst;
    logic             r_done, n_done;

    logic [2*DIM_W+AREA_W-DIM_W:0] prod_start;
    logic [DIM_W+AREA_W-1:0]       prod_back;
    logic [OFS_W-1:0]              start_u, back_u, unit_bytes;
    logic [DIM_W:0]                h_inc, v_inc;
    logic                          last;

    function automatic logic [OFS_W-1:0] f_scale(input logic [OFS_W-1:0] v,
                                                 input logic unit2);
        return unit2 ? {v[OFS_W-2:0], 1'b0} : v;
    endfunction

    always_comb begin
        prod_start = i_plan.hi * i_plan.dxdy;
        prod_back  = i_plan.ext_v_m1 * i_plan.vs;
        start_u    = f_scale(prod_start[OFS_W-1:0] + OFS_W'(i_plan.lo), i_plan.unit2);
        back_u     = f_scale(prod_back[OFS_W-1:0], i_plan.unit2);
        unit_bytes = i_plan.unit2 ? OFS_W'(2) : OFS_W'(1);
        h_inc      = {1'b0, r_horiz} + (DIM_W + 1)'(1);
        v_inc      = {1'b0, r_vert} + (DIM_W + 1)'(1);

        n_horiz    = r_horiz;
        n_vert     = r_vert;
        n_depth    = r_depth;
        n_row_base = r_row_base;
        n_src      = r_src;
        n_dst      = r_dst;
        n_done     = r_done;
        last       = 1'b0;
        o_result   = '0;

        if (i_restart) begin
            n_horiz = '0;
            n_vert  = '0;
            n_depth = '0;
            n_dst   = '0;
            if (i_plan.bad) begin
                n_row_base         = '0;
                n_src              = '0;
                n_done             = 1'b1;
                o_result.last      = 1'b1;
                o_result.error     = 1'b1;
                o_result.valid_res = 1'b1;
            end else begin
                n_row_base = start_u;
                n_src      = start_u;
                last       = (i_plan.ext_h == DIM_W'(1)) && (i_plan.ext_v == DIM_W'(1))
                          && (i_plan.ext_d == DIM_W'(1));
                n_done     = last;
                o_result.source_offset = start_u;
                o_result.last          = last;
                o_result.valid_res     = 1'b1;
            end
        end else if (!r_done) begin
            if (h_inc < {1'b0, i_plan.ext_h}) begin
                n_horiz = h_inc[DIM_W-1:0];
                n_src   = r_src + OFS_W'(i_plan.hs_u);
            end else begin
                n_horiz = '0;
                if (v_inc < {1'b0, i_plan.ext_v}) begin
                    n_vert     = v_inc[DIM_W-1:0];
                    n_row_base = r_row_base + OFS_W'(i_plan.vs_u);
                end else begin
                    // Next plane: step in depth and rewind the rows just walked.
                    n_vert     = '0;
                    n_depth    = r_depth + DIM_W'(1);
                    n_row_base = r_row_base + OFS_W'(i_plan.ds_u) - back_u;
                end
                n_src = n_row_base;
            end
            n_dst  = r_dst + unit_bytes;
            last   = (({1'b0, n_horiz} + (DIM_W + 1)'(1)) >= {1'b0, i_plan.ext_h})
                  && (({1'b0, n_vert} + (DIM_W + 1)'(1)) >= {1'b0, i_plan.ext_v})
                  && (({1'b0, n_depth} + (DIM_W + 1)'(1)) >= {1'b0, i_plan.ext_d});
            n_done = last;
            o_result.source_offset = n_src;
            o_result.dest_offset   = n_dst;
            o_result.last          = last;
            o_result.valid_res     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horiz    <= '0;
            r_vert     <= '0;
            r_depth    <= '0;
            r_row_base <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_done     <= 1'b1;
        end else if (i_fire) begin
            r_horiz    <= n_horiz;
            r_vert     <= n_vert;
            r_depth    <= n_depth;
            r_row_base <= n_row_base;
            r_src      <= n_src;
            r_dst      <= n_dst;
            r_done     <= n_done;
        end
    end

endmodule
